>>> rtl/core/tws_pkg.sv
`default_nettype none
package tws_pkg;

	// sizing
	localparam int unsigned MAX_SCREEN_ROWS  = 1024;
	localparam int unsigned MAX_TEXTURE_SIZE = 1024;
	localparam int unsigned FRACTION_BITS    = 16;

	// fixed field widths
	localparam int unsigned COL_W      = 12;
	localparam int unsigned DIST_W     = 32;
	localparam int unsigned FRAC_IN_W  = 16;
	localparam int unsigned ROW_OUT_W  = 10;
	localparam int unsigned TEX_OUT_W  = 10;
	localparam int unsigned SEL_W      = 2;
	localparam int unsigned CFG_W      = 11;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned LH_W       = 20;
	localparam int unsigned POS_W      = 32;

	// derived widths
	localparam int unsigned MAX_DIM    = (MAX_SCREEN_ROWS > MAX_TEXTURE_SIZE) ?
		MAX_SCREEN_ROWS : MAX_TEXTURE_SIZE;
	localparam int unsigned DIM_W      = $clog2(MAX_DIM + 1);
	localparam int unsigned ROW_W      = $clog2(MAX_SCREEN_ROWS);
	localparam int unsigned NUM_W      = DIM_W + FRACTION_BITS;
	localparam int unsigned OFF_W      = LH_W - 1;
	localparam int unsigned PROD_W     = OFF_W + POS_W;
	localparam int unsigned TXP_W      = FRAC_IN_W + DIM_W;
	localparam int unsigned SUM_W      = ((LH_W > DIM_W) ? LH_W : DIM_W) + 1;
	localparam int unsigned LH_CMP_W   = (NUM_W > LH_W) ? NUM_W : LH_W;
	localparam int unsigned STEP_CMP_W = (NUM_W > POS_W) ? NUM_W : POS_W;
	localparam int unsigned TY_W       = POS_W - FRACTION_BITS;
	localparam int unsigned TY_CMP_W   = (TY_W > DIM_W) ? TY_W : DIM_W;

	localparam logic [LH_W-1:0]  LH_MAX  = '1;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// register reset values and clamp limits
	localparam int unsigned SCREEN_HEIGHT_RST  = 480;
	localparam int unsigned TEXTURE_WIDTH_RST  = 64;
	localparam int unsigned TEXTURE_HEIGHT_RST = 64;
	localparam int unsigned SCREEN_ROWS_MIN    = 2;
	localparam int unsigned TEXTURE_SIZE_MIN   = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_HEIGHT = 2'd2;

	// opcodes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_NEXT = 1'b1;

	typedef enum logic [SEL_W-1:0] {
		FACE_NORTH = 2'd0,
		FACE_SOUTH = 2'd1,
		FACE_WEST  = 2'd2,
		FACE_EAST  = 2'd3
	} face_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_LH,
		ST_SPAN,
		ST_DIV_STEP,
		ST_POS,
		ST_DONE
	} state_t;

	// sequencer -> datapath
	typedef struct packed {
		logic in_ready;
		logic load_go;
		logic div_start;
		logic div_sel_step;
		logic lh_take;
		logic span_take;
		logic step_take;
		logic pos_take;
		logic finish;
	} ctrl_t;

	// datapath -> sequencer
	typedef struct packed {
		logic load_req;
		logic dist_zero;
		logic div_done;
		logic res_free;
	} stat_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
			input int unsigned lo, input int unsigned hi);
		logic [DIM_W-1:0] r;
		if (32'(v) < lo)
			r = DIM_W'(lo);
		else if (32'(v) > hi)
			r = DIM_W'(hi);
		else
			r = DIM_W'(v);
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/tws_if.sv
`default_nettype none
// column request channel
interface tws_req_if import tws_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 opcode;
	logic [COL_W-1:0]     screen_column;
	logic [DIST_W-1:0]    wall_distance;
	logic                 hit_face;
	logic                 dir_x_negative;
	logic                 dir_y_negative;
	logic                 dir_y_positive;
	logic [FRAC_IN_W-1:0] wall_fraction;

	modport source (output valid, opcode, screen_column, wall_distance, hit_face,
		dir_x_negative, dir_y_negative, dir_y_positive, wall_fraction, input ready);
	modport sink (input valid, opcode, screen_column, wall_distance, hit_face,
		dir_x_negative, dir_y_negative, dir_y_positive, wall_fraction, output ready);
endinterface

// result channel
interface tws_res_if import tws_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 pixel_valid;
	logic [COL_W-1:0]     screen_x;
	logic [ROW_OUT_W-1:0] screen_y;
	logic [SEL_W-1:0]     texture_select;
	logic [TEX_OUT_W-1:0] texel_x;
	logic [TEX_OUT_W-1:0] texel_y;
	logic                 last_pixel;
	logic [ROW_OUT_W-1:0] span_start;
	logic [ROW_OUT_W-1:0] span_end;

	modport source (output valid, pixel_valid, screen_x, screen_y, texture_select,
		texel_x, texel_y, last_pixel, span_start, span_end, input ready);
	modport sink (input valid, pixel_valid, screen_x, screen_y, texture_select,
		texel_x, texel_y, last_pixel, span_start, span_end, output ready);
endinterface

// register write channel
interface tws_cfg_if import tws_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tws_divider.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module tws_divider import tws_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [NUM_W-1:0]  dividend,
	input  wire logic [DIST_W-1:0] divisor,
	output logic                   done,
	output logic [NUM_W-1:0]       quotient
);
	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [DIST_W-1:0] rem_q;
	logic [DIST_W-1:0] den_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DIST_W:0]   trial;
	logic [DIST_W:0]   diff;
	logic              ge;
	logic [DIST_W-1:0] rem_nx;

	always_comb begin
		trial  = {rem_q, quo_q[NUM_W-1]};
		diff   = trial - {1'b0, den_q};
		ge     = (trial >= {1'b0, den_q});
		rem_nx = ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start)
				cnt_q <= CNT_W'(NUM_W);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

>>> rtl/core/tws_seq.sv
`default_nettype none
// load sequencer: height divide (skipped at zero distance), span setup, step divide, start position
module tws_seq import tws_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire stat_t stat,
	output ctrl_t      ctrl
);
	state_t state_q;
	state_t state_nx;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (stat.load_req && stat.res_free)
					state_nx = stat.dist_zero ? ST_SPAN : ST_DIV_LH;
			end
			ST_DIV_LH: begin
				if (stat.div_done)
					state_nx = ST_SPAN;
			end
			ST_SPAN: begin
				state_nx = ST_DIV_STEP;
			end
			ST_DIV_STEP: begin
				if (stat.div_done)
					state_nx = ST_POS;
			end
			ST_POS: begin
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (stat.res_free)
					state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctrl              = '0;
		ctrl.in_ready     = (state_q == ST_IDLE) && stat.res_free;
		ctrl.load_go      = ctrl.in_ready && stat.load_req;
		ctrl.div_sel_step = (state_q == ST_SPAN);
		ctrl.div_start    = (ctrl.load_go && !stat.dist_zero) || (state_q == ST_SPAN);
		ctrl.lh_take      = (state_q == ST_DIV_LH) && stat.div_done;
		ctrl.span_take    = (state_q == ST_SPAN);
		ctrl.step_take    = (state_q == ST_DIV_STEP) && stat.div_done;
		ctrl.pos_take     = (state_q == ST_POS);
		ctrl.finish       = (state_q == ST_DONE) && stat.res_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nx;
	end
endmodule
`default_nettype wire

>>> rtl/core/textured_wall_column_span_core.sv
`default_nettype none
// Channel  Modport  Moves                   Width / fields
// -------  -------  ----------------------  ---------------------------------------
// cfg      sink     register write request  index 2b, data 11b
// req      sink     column / pixel request  opcode, column, distance, face, signs, fraction
// res      source   one result per request  pixel flag, x, y, texture, texels, last, span
//
// A next-pixel request's result lands in the output register the next cycle, so pixels
// stream one per cycle while results are taken.
// A load request runs both divisions through one restoring divider, one bit a cycle;
// the height division is skipped when the distance is zero.
// arst_n clears the sequencer, the span flag and the output valid and returns the
// registers to 480/64/64. Requests stall while a result waits unless it is taken the
// same cycle; register writes are always taken.
module textured_wall_column_span_core import tws_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	tws_cfg_if.sink  cfg,
	tws_req_if.sink  req,
	tws_res_if.source res
);
	// register file
	logic [CFG_W-1:0] sh_cfg_q;
	logic [CFG_W-1:0] tw_cfg_q;
	logic [CFG_W-1:0] th_cfg_q;
	logic [DIM_W-1:0] sh_c;
	logic [DIM_W-1:0] tw_c;
	logic [DIM_W-1:0] th_c;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_cfg_q <= CFG_W'(SCREEN_HEIGHT_RST);
			tw_cfg_q <= CFG_W'(TEXTURE_WIDTH_RST);
			th_cfg_q <= CFG_W'(TEXTURE_HEIGHT_RST);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_SCREEN_HEIGHT:  sh_cfg_q <= cfg.data;
				REG_TEXTURE_WIDTH:  tw_cfg_q <= cfg.data;
				REG_TEXTURE_HEIGHT: th_cfg_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// out-of-range register values are used clamped
	assign sh_c = clamp_dim(sh_cfg_q, SCREEN_ROWS_MIN, MAX_SCREEN_ROWS);
	assign tw_c = clamp_dim(tw_cfg_q, TEXTURE_SIZE_MIN, MAX_TEXTURE_SIZE);
	assign th_c = clamp_dim(th_cfg_q, TEXTURE_SIZE_MIN, MAX_TEXTURE_SIZE);

	// sequencer
	ctrl_t ctrl;
	stat_t stat;
	logic  res_valid_q;
	logic  pixel_go;
	logic  div_done;
	logic [NUM_W-1:0] div_q;

	assign stat.load_req  = req.valid && (req.opcode == OP_LOAD);
	assign stat.dist_zero = (req.wall_distance == '0);
	assign stat.div_done  = div_done;
	assign stat.res_free  = !res_valid_q || res.ready;

	assign req.ready = ctrl.in_ready;
	assign pixel_go  = req.valid && ctrl.in_ready && (req.opcode == OP_NEXT);

	tws_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// shared divider: screen_height/distance, then texture_height/line_height
	logic [NUM_W-1:0]  div_num;
	logic [DIST_W-1:0] div_den;
	logic [LH_W-1:0]   lh_q;

	assign div_num = ctrl.div_sel_step ? {th_c, {FRACTION_BITS{1'b0}}}
	                                   : {sh_c, {FRACTION_BITS{1'b0}}};
	assign div_den = ctrl.div_sel_step ? DIST_W'(lh_q) : req.wall_distance;

	tws_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_q)
	);

	// hit capture
	logic                 face_q;
	logic                 xneg_q;
	logic                 yneg_q;
	logic                 ypos_q;
	logic [TXP_W-1:0]     tx_prod_q;
	logic [COL_W-1:0]     column_latch_q;

	always_ff @(posedge clk) begin
		if (ctrl.load_go) begin
			face_q         <= req.hit_face;
			xneg_q         <= req.dir_x_negative;
			yneg_q         <= req.dir_y_negative;
			ypos_q         <= req.dir_y_positive;
			tx_prod_q      <= TXP_W'(req.wall_fraction) * TXP_W'(tw_c);
			column_latch_q <= req.screen_column;
		end
	end

	// line height, floor 1, saturate at 2^20-1
	logic [LH_CMP_W-1:0] lh_wide;
	logic [LH_W-1:0]     lh_sat;

	always_comb begin
		lh_wide = LH_CMP_W'(div_q);
		if (lh_wide > LH_CMP_W'(LH_MAX))
			lh_sat = LH_MAX;
		else if (lh_wide == '0)
			lh_sat = LH_W'(1);
		else
			lh_sat = LH_W'(lh_wide);
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_go && stat.dist_zero)
			lh_q <= LH_MAX;
		else if (ctrl.lh_take)
			lh_q <= lh_sat;
	end

	// span setup: rows centered on the screen, clamped, plus the offset of the
	// first visible row into the wall when the wall is taller than the screen
	logic [SUM_W-1:0] half_w;
	logic [SUM_W-1:0] lhh_w;
	logic [SUM_W-1:0] sh_w;
	logic [SUM_W-1:0] s_w;
	logic [SUM_W-1:0] e_w;
	logic [SUM_W-1:0] off_w;
	logic [DIM_W-1:0] tx_raw;
	logic [DIM_W-1:0] tx_clip;
	logic [DIM_W-1:0] tx_fin;
	face_t            face_nx;

	always_comb begin
		half_w = SUM_W'(sh_c >> 1);
		lhh_w  = SUM_W'(lh_q >> 1);
		sh_w   = SUM_W'(sh_c);
		if (lhh_w >= half_w) begin
			s_w   = '0;
			off_w = lhh_w - half_w;
		end else begin
			s_w   = half_w - lhh_w;
			off_w = '0;
		end
		e_w = half_w + lhh_w;
		if (e_w >= sh_w)
			e_w = sh_w - SUM_W'(1);

		tx_raw  = tx_prod_q[TXP_W-1:FRAC_IN_W];
		tx_clip = (tx_raw >= tw_c) ? (tw_c - DIM_W'(1)) : tx_raw;
		// faces seen from behind read the texture mirrored
		if ((!face_q && xneg_q) || (face_q && ypos_q))
			tx_fin = tw_c - tx_clip - DIM_W'(1);
		else
			tx_fin = tx_clip;

		priority if (!face_q && xneg_q)
			face_nx = FACE_WEST;
		else if (!face_q)
			face_nx = FACE_EAST;
		else if (yneg_q)
			face_nx = FACE_NORTH;
		else
			face_nx = FACE_SOUTH;
	end

	// span state
	logic                 span_active_q;
	logic [ROW_W-1:0]     cur_row_q;
	logic [ROW_W-1:0]     start_row_q;
	logic [ROW_W-1:0]     end_row_q;
	logic [POS_W-1:0]     texel_pos_q;
	logic [POS_W-1:0]     step_q;
	face_t                face_sel_q;
	logic [TEX_OUT_W-1:0] texel_col_q;
	logic [OFF_W-1:0]     offset_q;
	logic [PROD_W-1:0]    pos_prod_q;

	// step saturates at 2^32-1
	logic [STEP_CMP_W-1:0] step_wide;
	logic [POS_W-1:0]      step_sat;
	logic [POS_W-1:0]      pos_start;

	always_comb begin
		step_wide = STEP_CMP_W'(div_q);
		step_sat  = (step_wide > STEP_CMP_W'(POS_MAX)) ? POS_MAX : POS_W'(step_wide);
		pos_start = (pos_prod_q[PROD_W-1:POS_W] != '0) ? POS_MAX : pos_prod_q[POS_W-1:0];
	end

	// pixel: texel row clamped to height-1, running position saturates
	logic [TY_CMP_W-1:0] ty_w;
	logic [TY_CMP_W-1:0] th_w;
	logic [TY_CMP_W-1:0] ty_c;
	logic [POS_W:0]      pos_sum;
	logic [POS_W-1:0]    pos_nx;
	logic                last_c;

	always_comb begin
		ty_w    = TY_CMP_W'(texel_pos_q[POS_W-1:FRACTION_BITS]);
		th_w    = TY_CMP_W'(th_c);
		ty_c    = (ty_w >= th_w) ? (th_w - TY_CMP_W'(1)) : ty_w;
		pos_sum = {1'b0, texel_pos_q} + {1'b0, step_q};
		pos_nx  = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
		last_c  = (cur_row_q >= end_row_q);
	end

	always_ff @(posedge clk) begin
		if (ctrl.span_take) begin
			start_row_q <= ROW_W'(s_w);
			end_row_q   <= ROW_W'(e_w);
			offset_q    <= OFF_W'(off_w);
			face_sel_q  <= face_nx;
			texel_col_q <= TEX_OUT_W'(tx_fin);
		end
		if (ctrl.step_take)
			step_q <= step_sat;
		if (ctrl.pos_take)
			pos_prod_q <= PROD_W'(offset_q) * PROD_W'(step_q);
		if (ctrl.finish) begin
			cur_row_q   <= start_row_q;
			texel_pos_q <= pos_start;
		end else if (pixel_go && span_active_q) begin
			texel_pos_q <= pos_nx;
			if (!last_c)
				cur_row_q <= cur_row_q + ROW_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			span_active_q <= 1'b0;
		else if (ctrl.finish)
			span_active_q <= 1'b1;
		else if (pixel_go && span_active_q && last_c)
			span_active_q <= 1'b0;
	end

	// output register
	logic                 res_pix_q;
	logic [COL_W-1:0]     res_x_q;
	logic [ROW_OUT_W-1:0] res_y_q;
	face_t                res_sel_q;
	logic [TEX_OUT_W-1:0] res_tx_q;
	logic [TEX_OUT_W-1:0] res_ty_q;
	logic                 res_last_q;
	logic [ROW_OUT_W-1:0] res_s0_q;
	logic [ROW_OUT_W-1:0] res_s1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (ctrl.finish || pixel_go)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			// load result reports the new span, no pixel
			res_pix_q  <= 1'b0;
			res_x_q    <= column_latch_q;
			res_y_q    <= '0;
			res_sel_q  <= face_sel_q;
			res_tx_q   <= texel_col_q;
			res_ty_q   <= '0;
			res_last_q <= 1'b0;
			res_s0_q   <= ROW_OUT_W'(start_row_q);
			res_s1_q   <= ROW_OUT_W'(end_row_q);
		end else if (pixel_go) begin
			if (span_active_q) begin
				res_pix_q  <= 1'b1;
				res_x_q    <= column_latch_q;
				res_y_q    <= ROW_OUT_W'(cur_row_q);
				res_sel_q  <= face_sel_q;
				res_tx_q   <= texel_col_q;
				res_ty_q   <= TEX_OUT_W'(ty_c);
				res_last_q <= last_c;
				res_s0_q   <= ROW_OUT_W'(start_row_q);
				res_s1_q   <= ROW_OUT_W'(end_row_q);
			end else begin
				// next with no span: all-zero result
				res_pix_q  <= 1'b0;
				res_x_q    <= '0;
				res_y_q    <= '0;
				res_sel_q  <= FACE_NORTH;
				res_tx_q   <= '0;
				res_ty_q   <= '0;
				res_last_q <= 1'b0;
				res_s0_q   <= '0;
				res_s1_q   <= '0;
			end
		end
	end

	assign res.valid          = res_valid_q;
	assign res.pixel_valid    = res_pix_q;
	assign res.screen_x       = res_x_q;
	assign res.screen_y       = res_y_q;
	assign res.texture_select = res_sel_q;
	assign res.texel_x        = res_tx_q;
	assign res.texel_y        = res_ty_q;
	assign res.last_pixel     = res_last_q;
	assign res.span_start     = res_s0_q;
	assign res.span_end       = res_s1_q;
endmodule
`default_nettype wire

>>> rtl/core/tws_checker.sv
`default_nettype none
module tws_checker import tws_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 req_valid,
	input wire logic                 req_ready,
	input wire logic                 req_opcode,
	input wire logic                 res_valid,
	input wire logic                 res_ready,
	input wire logic                 res_pixel_valid,
	input wire logic [COL_W-1:0]     res_screen_x,
	input wire logic [ROW_OUT_W-1:0] res_screen_y,
	input wire logic [TEX_OUT_W-1:0] res_texel_y,
	input wire logic [ROW_OUT_W-1:0] res_span_start,
	input wire logic [ROW_OUT_W-1:0] res_span_end
);
	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_screen_x)
			&& $stable(res_screen_y) && $stable(res_texel_y))
		else $error("result changed while stalled");

	// a pixel request yields a result on the next cycle
	a_pixel_next: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_opcode == OP_NEXT) |=> res_valid)
		else $error("pixel request produced no result");

	// a load occupies the divider, no request taken right after
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_opcode == OP_LOAD) |=> !req_ready)
		else $error("request taken during column load");

	// drawn rows stay inside the span
	a_row_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_pixel_valid |->
			(res_span_start <= res_screen_y) && (res_screen_y <= res_span_end))
		else $error("pixel row outside span");
endmodule

bind textured_wall_column_span_core tws_checker u_tws_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_opcode      (req.opcode),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_pixel_valid (res.pixel_valid),
	.res_screen_x    (res.screen_x),
	.res_screen_y    (res.screen_y),
	.res_texel_y     (res.texel_y),
	.res_span_start  (res.span_start),
	.res_span_end    (res.span_end)
);
`default_nettype wire
